/* rtl/core/smt_pkg.sv */
// Shared types and constants for the SPI master transfer block.
// No dependencies; used by spi_master_transfer, smt_checker and the testbench.
`default_nettype none

package smt_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;
    localparam int LEN_W      = 16;
    localparam int BYTE_W     = 8;
    localparam int BIT_CNT_W  = 3;

    localparam logic [BIT_CNT_W-1:0] BIT_LAST = 3'd7;

    // func field codes
    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_TICK  = 1'b1;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SPI_MODE      = 3'd0,
        REG_MSB_FIRST     = 3'd1,
        REG_TOGGLE_SELECT = 3'd2,
        REG_DRIVE_MOSI    = 3'd3,
        REG_SAMPLE_MISO   = 3'd4
    } cfg_reg_t;

    // one result beat
    typedef struct packed {
        logic              sclk;
        logic              mosi;
        logic              select_n;
        logic              need_tx;
        logic [BYTE_W-1:0] rx_byte;
        logic              rx_valid;
        logic              rx_last;
        logic              busy_res;
    } result_t;

endpackage

`default_nettype wire

/* rtl/core/spi_master_transfer.sv */
// SPI master, modes 0 to 3, one item per half bit period.
// The result beat of an item is registered and shown in the cycle after it is accepted.
// Throughput: one item per cycle; the result register is the only stage, so a
// new beat is taken whenever the result register is empty or being drained.
// Reset: all control state cleared, select high, config back to mode 0 MSB-first with all flags set.
// Depends on smt_pkg.
`default_nettype none

module spi_master_transfer (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // configuration write channel
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [smt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [smt_pkg::CFG_DATA_W-1:0] cfg_data,
    // input channel
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic                           func,
    input  wire logic [smt_pkg::LEN_W-1:0]      read_len,
    input  wire logic [smt_pkg::LEN_W-1:0]      write_len,
    input  wire logic [smt_pkg::BYTE_W-1:0]     tx_byte,
    input  wire logic                           miso,
    // result channel
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic                                sclk,
    output logic                                mosi,
    output logic                                select_n,
    output logic                                need_tx,
    output logic [smt_pkg::BYTE_W-1:0]          rx_byte,
    output logic                                rx_valid,
    output logic                                rx_last,
    output logic                                busy_res
);

    // configuration
    logic [1:0] spi_mode_reg;
    logic       msb_first_reg;
    logic       toggle_select_reg;
    logic       drive_mosi_reg;
    logic       sample_miso_reg;

    // transfer state
    logic                            active_reg,      active_next;
    logic                            half_phase_reg,  half_phase_next;
    logic [smt_pkg::BIT_CNT_W-1:0]   bit_count_reg,   bit_count_next;
    logic [smt_pkg::LEN_W-1:0]       reads_left_reg,  reads_left_next;
    logic [smt_pkg::LEN_W-1:0]       writes_left_reg, writes_left_next;
    logic [smt_pkg::BYTE_W-1:0]      tx_shift_reg,    tx_shift_next;
    logic [smt_pkg::BYTE_W-1:0]      rx_shift_reg,    rx_shift_next;
    logic                            clock_level_reg, clock_level_next;
    logic                            data_out_reg,    data_out_next;
    logic                            select_reg,      select_next;

    // result register
    logic             out_valid_reg;
    smt_pkg::result_t result_reg, result_next;

    logic accept;

    assign cfg_ready = 1'b1;
    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spi_mode_reg      <= 2'd0;
            msb_first_reg     <= 1'b1;
            toggle_select_reg <= 1'b1;
            drive_mosi_reg    <= 1'b1;
            sample_miso_reg   <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                smt_pkg::REG_SPI_MODE:      spi_mode_reg      <= cfg_data[1:0];
                smt_pkg::REG_MSB_FIRST:     msb_first_reg     <= cfg_data[0];
                smt_pkg::REG_TOGGLE_SELECT: toggle_select_reg <= cfg_data[0];
                smt_pkg::REG_DRIVE_MOSI:    drive_mosi_reg    <= cfg_data[0];
                smt_pkg::REG_SAMPLE_MISO:   sample_miso_reg   <= cfg_data[0];
                default:                    ;
            endcase
        end
    end

    // one item's step
    always_comb
    begin
        logic                          cpol;
        logic                          cpha;
        logic [smt_pkg::BIT_CNT_W-1:0] pos;
        logic [smt_pkg::BYTE_W-1:0]    tx_v;
        logic [smt_pkg::BYTE_W-1:0]    rx_v;
        logic [smt_pkg::LEN_W-1:0]     reads_v;
        logic                          rvalid;
        logic                          rlast;
        logic [smt_pkg::BYTE_W-1:0]    rbyte;

        cpol = spi_mode_reg[1];
        cpha = spi_mode_reg[0];
        pos  = msb_first_reg ? ~bit_count_reg : bit_count_reg;
        tx_v    = tx_shift_reg;
        rx_v    = rx_shift_reg;
        reads_v = reads_left_reg;
        rvalid  = 1'b0;
        rlast   = 1'b0;
        rbyte   = '0;

        active_next      = active_reg;
        half_phase_next  = half_phase_reg;
        bit_count_next   = bit_count_reg;
        reads_left_next  = reads_left_reg;
        writes_left_next = writes_left_reg;
        tx_shift_next    = tx_shift_reg;
        rx_shift_next    = rx_shift_reg;
        clock_level_next = clock_level_reg;
        data_out_next    = data_out_reg;
        select_next      = select_reg;

        if (func == smt_pkg::FUNC_START)
        begin
            reads_left_next  = read_len;
            writes_left_next = write_len;
            half_phase_next  = 1'b0;
            bit_count_next   = '0;
            tx_shift_next    = '0;
            rx_shift_next    = '0;
            clock_level_next = cpol;
            active_next      = (read_len != '0) || (write_len != '0);
            if (toggle_select_reg)
                select_next = !active_next;
        end
        else if (active_reg)
        begin
            if (!half_phase_reg)
            begin
                // leading half: new byte slot loads the shifter
                if (bit_count_reg == '0)
                begin
                    if (writes_left_reg != '0)
                    begin
                        tx_v             = tx_byte;
                        writes_left_next = writes_left_reg - 16'd1;
                    end
                    else
                        tx_v = '0;
                    rx_v = '0;
                end
                if (drive_mosi_reg)
                    data_out_next = tx_v[pos];
                if (!cpha && sample_miso_reg)
                    rx_v[pos] = miso;
                clock_level_next = ~cpol;
                half_phase_next  = 1'b1;
                tx_shift_next    = tx_v;
                rx_shift_next    = rx_v;
            end
            else
            begin
                // trailing half: clock back to idle, CPHA 1 samples here
                if (cpha && sample_miso_reg)
                    rx_v[pos] = miso;
                rx_shift_next    = rx_v;
                clock_level_next = cpol;
                half_phase_next  = 1'b0;
                if (bit_count_reg == smt_pkg::BIT_LAST)
                begin
                    bit_count_next = '0;
                    if (reads_v != '0)
                    begin
                        rvalid  = 1'b1;
                        rbyte   = rx_v;
                        rlast   = (reads_v == 16'd1);
                        reads_v = reads_v - 16'd1;
                    end
                    reads_left_next = reads_v;
                    if (reads_v == '0 && writes_left_reg == '0)
                    begin
                        active_next = 1'b0;
                        if (toggle_select_reg)
                            select_next = 1'b1;
                    end
                end
                else
                    bit_count_next = bit_count_reg + 3'd1;
            end
        end

        result_next.sclk     = clock_level_next;
        result_next.mosi     = data_out_next;
        result_next.select_n = select_next;
        result_next.need_tx  = active_next && !half_phase_next &&
                               (bit_count_next == '0) && (writes_left_next != '0);
        result_next.rx_byte  = rbyte;
        result_next.rx_valid = rvalid;
        result_next.rx_last  = rlast;
        result_next.busy_res = active_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg      <= 1'b0;
            half_phase_reg  <= 1'b0;
            bit_count_reg   <= '0;
            reads_left_reg  <= '0;
            writes_left_reg <= '0;
            tx_shift_reg    <= '0;
            rx_shift_reg    <= '0;
            clock_level_reg <= 1'b0;
            data_out_reg    <= 1'b0;
            select_reg      <= 1'b1;
        end
        else if (accept)
        begin
            active_reg      <= active_next;
            half_phase_reg  <= half_phase_next;
            bit_count_reg   <= bit_count_next;
            reads_left_reg  <= reads_left_next;
            writes_left_reg <= writes_left_next;
            tx_shift_reg    <= tx_shift_next;
            rx_shift_reg    <= rx_shift_next;
            clock_level_reg <= clock_level_next;
            data_out_reg    <= data_out_next;
            select_reg      <= select_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            result_reg <= result_next;
    end

    assign out_valid = out_valid_reg;
    assign sclk      = result_reg.sclk;
    assign mosi      = result_reg.mosi;
    assign select_n  = result_reg.select_n;
    assign need_tx   = result_reg.need_tx;
    assign rx_byte   = result_reg.rx_byte;
    assign rx_valid  = result_reg.rx_valid;
    assign rx_last   = result_reg.rx_last;
    assign busy_res  = result_reg.busy_res;

endmodule

`default_nettype wire

/* rtl/core/smt_checker.sv */
// Port-level checks for spi_master_transfer, attached by bind.
// Depends on smt_pkg and the top level's port list.
`default_nettype none

module smt_checker (
    input wire logic                       clk,
    input wire logic                       rst_n,
    input wire logic                       in_valid,
    input wire logic                       in_ready,
    input wire logic                       out_valid,
    input wire logic                       out_ready,
    input wire logic                       need_tx,
    input wire logic [smt_pkg::BYTE_W-1:0] rx_byte,
    input wire logic                       rx_valid,
    input wire logic                       rx_last,
    input wire logic                       busy_res
);

    // a stalled result beat is held
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result beat dropped while stalled");

    // every accepted item yields a beat in the next cycle
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("accepted item gave no result beat");

    a_last_has_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && rx_last |-> rx_valid)
        else $error("rx_last without rx_valid");

    a_rx_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !rx_valid |-> rx_byte == '0)
        else $error("rx_byte non-zero on a beat with no read byte");

    // no write byte is asked for once the transfer has ended
    a_idle_no_tx: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !busy_res |-> !need_tx)
        else $error("need_tx raised while idle");

endmodule

bind spi_master_transfer smt_checker u_smt_checker (.*);

`default_nettype wire

/* tb/tb_spi_master_transfer.sv */
`timescale 1ns / 100ps
// Self-checking bench for spi_master_transfer: directed table, then random phases.
// Holds its own model of the SPI master and checks each result beat against it.
// Depends on smt_pkg and spi_master_transfer.

module tb_spi_master_transfer;

    import smt_pkg::*;

    localparam int ITEMS_TOTAL = 1400;
    localparam int QUIET_FROM  = 1200;
    localparam int DIR_N       = 25;

    typedef struct packed {
        logic              func;
        logic [LEN_W-1:0]  rlen;
        logic [LEN_W-1:0]  wlen;
        logic [BYTE_W-1:0] txb;
        logic              mi;
        logic              typed;
        result_t           beat;
    } stim_row_t;

    localparam result_t AFTER_RESET = '{select_n: 1'b1, default: '0};

    // Mode 0, MSB first throughout. A 1/1 transfer clocks out 0xA5 and reads 0xB2.
    localparam stim_row_t DIR_TBL [DIR_N] = '{
        '{FUNC_TICK,  16'h0000, 16'h0000, 8'h00, 1'b1, 1'b1, AFTER_RESET},
        '{FUNC_START, 16'h0000, 16'h0000, 8'hFF, 1'b1, 1'b1, AFTER_RESET},
        '{FUNC_TICK,  16'hFFFF, 16'hFFFF, 8'hFF, 1'b1, 1'b1, AFTER_RESET},
        '{FUNC_START, 16'hFFFF, 16'hFFFF, 8'h00, 1'b0, 1'b0, '0},
        '{FUNC_TICK,  16'h0000, 16'h0000, 8'hFF, 1'b1, 1'b0, '0},
        '{FUNC_TICK,  16'h0000, 16'h0000, 8'h00, 1'b0, 1'b0, '0},
        '{FUNC_START, 16'h0001, 16'h0001, 8'h00, 1'b0, 1'b0, '0},
        '{FUNC_TICK,  16'h0000, 16'h0000, 8'hA5, 1'b1, 1'b0, '0},
        '{FUNC_TICK,  16'h0000, 16'h0000, 8'h3C, 1'b0, 1'b0, '0},
        '{FUNC_TICK,  16'h0000, 16'h0000, 8'h3C, 1'b0, 1'b0, '0},
        '{FUNC_TICK,  16'h0000, 16'h0000, 8'h3C, 1'b1, 1'b0, '0},
        '{FUNC_TICK,  16'h0000, 16'h0000, 8'h3C, 1'b1, 1'b0, '0},
        '{FUNC_TICK,  16'h0000, 16'h0000, 8'h3C, 1'b0, 1'b0, '0},
        '{FUNC_TICK,  16'h0000, 16'h0000, 8'h3C, 1'b1, 1'b0, '0},
        '{FUNC_TICK,  16'h0000, 16'h0000, 8'h3C, 1'b0, 1'b0, '0},
        '{FUNC_TICK,  16'h0000, 16'h0000, 8'h3C, 1'b0, 1'b0, '0},
        '{FUNC_TICK,  16'h0000, 16'h0000, 8'h3C, 1'b1, 1'b0, '0},
        '{FUNC_TICK,  16'h0000, 16'h0000, 8'h3C, 1'b0, 1'b0, '0},
        '{FUNC_TICK,  16'h0000, 16'h0000, 8'h3C, 1'b1, 1'b0, '0},
        '{FUNC_TICK,  16'h0000, 16'h0000, 8'h3C, 1'b1, 1'b0, '0},
        '{FUNC_TICK,  16'h0000, 16'h0000, 8'h3C, 1'b0, 1'b0, '0},
        '{FUNC_TICK,  16'h0000, 16'h0000, 8'h3C, 1'b0, 1'b0, '0},
        '{FUNC_TICK,  16'h0000, 16'h0000, 8'h3C, 1'b1, 1'b0, '0},
        '{FUNC_TICK,  16'h0000, 16'h0000, 8'h3C, 1'b1, 1'b0, '0},
        '{FUNC_START, 16'h0000, 16'h0002, 8'h00, 1'b0, 1'b0, '0}
    };

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic                  func = FUNC_START;
    logic [LEN_W-1:0]      read_len = '0;
    logic [LEN_W-1:0]      write_len = '0;
    logic [BYTE_W-1:0]     tx_byte = '0;
    logic                  miso = 1'b0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic                  sclk, mosi, select_n, need_tx;
    logic [BYTE_W-1:0]     rx_byte;
    logic                  rx_valid, rx_last, busy_res;

    spi_master_transfer DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .func      (func),
        .read_len  (read_len),
        .write_len (write_len),
        .tx_byte   (tx_byte),
        .miso      (miso),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sclk      (sclk),
        .mosi      (mosi),
        .select_n  (select_n),
        .need_tx   (need_tx),
        .rx_byte   (rx_byte),
        .rx_valid  (rx_valid),
        .rx_last   (rx_last),
        .busy_res  (busy_res)
    );

    always #5 clk = ~clk;

    // shadow of the configuration registers
    logic [1:0] cfg_mode = 2'd0;
    logic       cfg_msb_first = 1'b1;
    logic       cfg_toggle_sel = 1'b1;
    logic       cfg_drive_mosi = 1'b1;
    logic       cfg_sample_miso = 1'b1;

    // model state of the serial engine
    logic                 xfer_on = 1'b0;
    logic                 second_half = 1'b0;
    logic [BIT_CNT_W-1:0] bit_cnt = '0;
    logic [LEN_W-1:0]     reads_left = '0;
    logic [LEN_W-1:0]     writes_left = '0;
    logic [BYTE_W-1:0]    tx_sr = '0;
    logic [BYTE_W-1:0]    rx_sr = '0;
    logic                 clk_lvl = 1'b0;
    logic                 dout_lvl = 1'b0;
    logic                 sel_lvl = 1'b1;

    result_t pending_beats [$];
    int      items_sent = 0;
    int      mismatch_count = 0;
    logic    no_idle = 1'b0;
    int      stall_left = 0;

    function automatic result_t predict_spi_beat(logic f, logic [LEN_W-1:0] rl,
                                                 logic [LEN_W-1:0] wl,
                                                 logic [BYTE_W-1:0] txb, logic mi);
        result_t              r;
        logic                 cpol;
        logic                 cpha;
        logic [BIT_CNT_W-1:0] pos;
        cpol = cfg_mode[1];
        cpha = cfg_mode[0];
        r = '0;
        if (f == FUNC_START) begin
            reads_left  = rl;
            writes_left = wl;
            second_half = 1'b0;
            bit_cnt     = '0;
            tx_sr       = '0;
            rx_sr       = '0;
            clk_lvl     = cpol;
            xfer_on     = (rl != 0) || (wl != 0);
            if (cfg_toggle_sel)
                sel_lvl = !xfer_on;
        end
        else if (xfer_on) begin
            pos = cfg_msb_first ? BIT_LAST - bit_cnt : bit_cnt;
            if (!second_half) begin
                if (bit_cnt == 0) begin
                    if (writes_left != 0) begin
                        tx_sr = txb;
                        writes_left--;
                    end
                    else
                        tx_sr = '0;
                    rx_sr = '0;
                end
                clk_lvl = !cpol;
                if (cfg_drive_mosi)
                    dout_lvl = tx_sr[pos];
                if (!cpha && cfg_sample_miso)
                    rx_sr[pos] = mi;
                second_half = 1'b1;
            end
            else begin
                clk_lvl = cpol;
                if (cpha && cfg_sample_miso)
                    rx_sr[pos] = mi;
                second_half = 1'b0;
                if (bit_cnt == BIT_LAST) begin
                    bit_cnt = '0;
                    if (reads_left != 0) begin
                        r.rx_valid = 1'b1;
                        r.rx_byte  = rx_sr;
                        r.rx_last  = (reads_left == 1);
                        reads_left--;
                    end
                    if (reads_left == 0 && writes_left == 0) begin
                        xfer_on = 1'b0;
                        if (cfg_toggle_sel)
                            sel_lvl = 1'b1;
                    end
                end
                else
                    bit_cnt++;
            end
        end
        r.sclk     = clk_lvl;
        r.mosi     = dout_lvl;
        r.select_n = sel_lvl;
        r.need_tx  = xfer_on && !second_half && bit_cnt == 0 && writes_left != 0;
        r.busy_res = xfer_on;
        return r;
    endfunction

    function automatic void flag_field(string nm, int unsigned want, int unsigned got);
        if (want != got) begin
            if (mismatch_count < 10)
                $display("%0t: %s mismatch, expected %0h got %0h", $time, nm, want, got);
            mismatch_count++;
        end
    endfunction

    function automatic logic [LEN_W-1:0] pick_len();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel < 6)
            return LEN_W'($urandom_range(0, 2));
        else if (sel < 9)
            return LEN_W'($urandom_range(0, 6));
        return LEN_W'($urandom_range(0, 12));
    endfunction

    task automatic send_item(logic f, logic [LEN_W-1:0] rl, logic [LEN_W-1:0] wl,
                             logic [BYTE_W-1:0] txb, logic mi,
                             logic typed = 1'b0, result_t typed_beat = '0);
        result_t want;
        if (!no_idle && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        func      <= f;
        read_len  <= rl;
        write_len <= wl;
        tx_byte   <= txb;
        miso      <= mi;
        do @(posedge clk); while (!in_ready);
        want = predict_spi_beat(f, rl, wl, txb, mi);
        pending_beats.push_back(typed ? typed_beat : want);
        items_sent++;
        if (items_sent >= QUIET_FROM)
            no_idle = 1'b1;
    endtask

    task automatic send_tick();
        send_item(FUNC_TICK, LEN_W'($urandom), LEN_W'($urandom), BYTE_W'($urandom),
                  1'($urandom));
    endtask

    // valid is left high between writes; the caller lowers it after the batch
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_SPI_MODE:      cfg_mode = d[1:0];
            REG_MSB_FIRST:     cfg_msb_first = d[0];
            REG_TOGGLE_SELECT: cfg_toggle_sel = d[0];
            REG_DRIVE_MOSI:    cfg_drive_mosi = d[0];
            REG_SAMPLE_MISO:   cfg_sample_miso = d[0];
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_beats.size() != 0)
            @(posedge clk);
    endtask

    // mode cycles through 0..3 phase by phase; upper data bits are junk
    task automatic set_up_phase(int unsigned ph);
        logic [CFG_DATA_W-1:0] d;
        d = CFG_DATA_W'($urandom);
        d[1:0] = 2'(ph % 4);
        write_reg(REG_SPI_MODE, d);
        write_reg(REG_MSB_FIRST, CFG_DATA_W'($urandom));
        write_reg(REG_TOGGLE_SELECT, CFG_DATA_W'($urandom));
        d = CFG_DATA_W'($urandom);
        d[0] = ($urandom_range(0, 4) != 0);
        write_reg(REG_DRIVE_MOSI, d);
        d = CFG_DATA_W'($urandom);
        d[0] = ($urandom_range(0, 4) != 0);
        write_reg(REG_SAMPLE_MISO, d);
        if ($urandom_range(0, 3) == 0)
            write_reg(CFG_IDX_W'($urandom_range(REG_SAMPLE_MISO + 1, (1 << CFG_IDX_W) - 1)),
                      CFG_DATA_W'($urandom));
        cfg_valid <= 1'b0;
    endtask

    always @(posedge clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end
        else if (rst_n && !no_idle && $urandom_range(0, 11) == 0) begin
            stall_left <= $urandom_range(1, 18) - 1;
            out_ready  <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk) begin : beat_check
        result_t got;
        result_t want;
        if (rst_n && out_valid && out_ready) begin
            got = '{sclk, mosi, select_n, need_tx, rx_byte, rx_valid, rx_last, busy_res};
            if (pending_beats.size() == 0) begin
                if (mismatch_count < 10)
                    $display("%0t: result beat with nothing expected", $time);
                mismatch_count++;
            end
            else begin
                want = pending_beats.pop_front();
                flag_field("sclk", want.sclk, got.sclk);
                flag_field("mosi", want.mosi, got.mosi);
                flag_field("select_n", want.select_n, got.select_n);
                flag_field("need_tx", want.need_tx, got.need_tx);
                flag_field("rx_byte", want.rx_byte, got.rx_byte);
                flag_field("rx_valid", want.rx_valid, got.rx_valid);
                flag_field("rx_last", want.rx_last, got.rx_last);
                flag_field("busy_res", want.busy_res, got.busy_res);
            end
        end
    end

    initial begin : stimulus
        int unsigned      phase;
        int unsigned      kind;
        int unsigned      n_ticks;
        logic [LEN_W-1:0] rl;
        logic [LEN_W-1:0] wl;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIR_N; i++)
            send_item(DIR_TBL[i].func, DIR_TBL[i].rlen, DIR_TBL[i].wlen, DIR_TBL[i].txb,
                      DIR_TBL[i].mi, DIR_TBL[i].typed, DIR_TBL[i].beat);

        // config is rewritten with the beat queue empty, often mid-transfer
        phase = 0;
        while (items_sent < ITEMS_TOTAL) begin
            wait_drained();
            set_up_phase(phase);
            phase++;
            repeat ($urandom_range(1, 4)) begin
                kind = $urandom_range(0, 9);
                if (kind < 8) begin
                    rl = pick_len();
                    wl = pick_len();
                    send_item(FUNC_START, rl, wl, BYTE_W'($urandom), 1'($urandom));
                    n_ticks = 2 * BYTE_W * ((rl > wl) ? rl : wl) + $urandom_range(0, 3);
                    repeat (n_ticks) send_tick();
                end
                else if (kind == 8) begin
                    // full-width counts, cut short by whatever comes next
                    send_item(FUNC_START, LEN_W'($urandom), LEN_W'($urandom),
                              BYTE_W'($urandom), 1'($urandom));
                    repeat ($urandom_range(0, 40)) send_tick();
                end
                else begin
                    repeat ($urandom_range(1, 8))
                        send_item(1'($urandom), LEN_W'($urandom_range(0, 3)),
                                  LEN_W'($urandom_range(0, 3)), BYTE_W'($urandom),
                                  1'($urandom));
                end
            end
        end

        wait_drained();
        repeat (4) @(posedge clk);
        if (mismatch_count == 0 && pending_beats.size() == 0)
            $display("spi_master_transfer regression: pass");
        else
            $display("spi_master_transfer regression: fail");
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("spi_master_transfer regression: fail");
        $finish;
    end

endmodule
